FILE: rtl/ipv4pv_pkg.sv
package ipv4pv_pkg;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned VALUE_W = 17;

  localparam logic [VALUE_W-1:0] OCTET_MAX = 17'd255;
  localparam logic [VALUE_W-1:0] PORT_MAX  = 17'd65535;
  localparam logic [VALUE_W-1:0] VALUE_CAP = 17'd65536;

  localparam logic [2:0] DOT_SAT    = 3'd7;
  localparam logic [1:0] COLON_SAT  = 2'd3;
  localparam logic [2:0] NUMBER_SAT = 3'd7;

  localparam logic [2:0] DOTS_NEEDED    = 3'd3;
  localparam logic [1:0] COLONS_NEEDED  = 2'd1;
  localparam logic [2:0] NUMBERS_NEEDED = 3'd5;
  localparam logic [2:0] OCTET_FIELDS   = 3'd5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

endpackage

FILE: rtl/ipv4pv_core.sv
module ipv4pv_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ipv4pv_pkg::item_t   item,
  output logic                verdict
);
  import ipv4pv_pkg::*;

  logic [2:0]         dot_count;
  logic [1:0]         colon_count;
  logic [2:0]         number_count;
  logic [VALUE_W-1:0] field_value;
  logic               at_start;
  logic               prev_was_separator;
  logic               prev_was_zero;
  logic               rejected;

  logic [2:0]         dot_count_next;
  logic [1:0]         colon_count_next;
  logic [2:0]         number_count_next;
  logic [VALUE_W-1:0] field_value_next;
  logic               at_start_next;
  logic               prev_was_separator_next;
  logic               prev_was_zero_next;
  logic               rejected_next;

  logic               is_digit;
  logic               is_dot;
  logic               is_colon;
  logic               is_sep;
  logic [7:0]         digit_val;
  logic [20:0]        scaled;

  assign is_digit  = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
  assign is_dot    = item.char_code == CHAR_DOT;
  assign is_colon  = item.char_code == CHAR_COLON;
  assign is_sep    = is_dot || is_colon;
  assign digit_val = item.char_code - CHAR_ZERO;
  // value * 10 + digit, as (v << 3) + (v << 1)
  assign scaled    = {1'b0, field_value, 3'b000} + {3'b000, field_value, 1'b0}
                   + {13'd0, digit_val};

  always_comb begin
    dot_count_next          = dot_count;
    colon_count_next        = colon_count;
    number_count_next       = number_count;
    field_value_next        = field_value;
    at_start_next           = at_start;
    prev_was_separator_next = prev_was_separator;
    prev_was_zero_next      = prev_was_zero;
    rejected_next           = rejected;
    if (!rejected) begin
      if ((at_start || prev_was_separator) && is_digit && number_count != NUMBER_SAT) begin
        number_count_next = number_count + 3'd1;
      end
      if (is_sep) begin
        if (is_dot && dot_count != DOT_SAT) begin
          dot_count_next = dot_count + 3'd1;
        end
        if (is_colon && colon_count != COLON_SAT) begin
          colon_count_next = colon_count + 2'd1;
        end
        // colon ahead of the third dot
        if (dot_count_next < DOTS_NEEDED && colon_count_next != 2'd0) begin
          rejected_next = 1'b1;
        end
        if (number_count_next == 3'd0) begin
          rejected_next = 1'b1;
        end
        if (number_count_next < OCTET_FIELDS && field_value > OCTET_MAX) begin
          rejected_next = 1'b1;
        end
        field_value_next = '0;
      end else if (!is_digit) begin
        rejected_next = 1'b1;
      end else if (!at_start && field_value == '0 && prev_was_zero) begin
        rejected_next = 1'b1;
      end else begin
        field_value_next = (scaled > {4'd0, VALUE_CAP}) ? VALUE_CAP : scaled[VALUE_W-1:0];
      end
      at_start_next           = 1'b0;
      prev_was_separator_next = is_sep;
      prev_was_zero_next      = item.char_code == CHAR_ZERO;
    end
  end

  assign verdict = !rejected_next && field_value_next <= PORT_MAX
                && dot_count_next == DOTS_NEEDED && colon_count_next == COLONS_NEEDED
                && number_count_next == NUMBERS_NEEDED;

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      dot_count          <= '0;
      colon_count        <= '0;
      number_count       <= '0;
      field_value        <= '0;
      at_start           <= 1'b1;
      prev_was_separator <= 1'b0;
      prev_was_zero      <= 1'b0;
      rejected           <= 1'b0;
    end else if (step) begin
      dot_count          <= dot_count_next;
      colon_count        <= colon_count_next;
      number_count       <= number_count_next;
      field_value        <= field_value_next;
      at_start           <= at_start_next;
      prev_was_separator <= prev_was_separator_next;
      prev_was_zero      <= prev_was_zero_next;
      rejected           <= rejected_next;
    end
  end

  a_value_capped: assert property (@(posedge clk) disable iff (rst)
    field_value <= VALUE_CAP)
    else $error("field value above cap");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_char |=> at_start && !rejected && dot_count == 3'd0
                               && number_count == 3'd0)
    else $error("state not cleared after last item");

  a_rejected_sticks: assert property (@(posedge clk) disable iff (rst)
    rejected && step && !item.last_char |=> rejected)
    else $error("rejection lost within string");

  a_rejected_fails: assert property (@(posedge clk) disable iff (rst)
    rejected |-> !verdict)
    else $error("rejected string passes");

endmodule

FILE: rtl/ipv4_port_text_validator.sv
// channel  | signals                                  | direction
// ---------+------------------------------------------+----------
// in       | in_valid, in_ready, char_code, last_char | into block
// out      | out_valid, out_ready, address_valid      | out of block
//
// One item per cycle sustained unless a stalled verdict holds stage one; a verdict
// is registered as its last item leaves stage one. Stage one registers the item,
// stage two updates the string state and loads the verdict register. rst is
// synchronous and returns the block to an empty string. A stalled verdict holds
// stage one only when it also carries a last item; other items keep flowing.
module ipv4_port_text_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       address_valid
);
  import ipv4pv_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  s1_advance;
  logic  verdict;

  assign s1_advance = s1_valid && (!s1_item.last_char || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item.char_code <= char_code;
      s1_item.last_char <= last_char;
    end
  end

  ipv4pv_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_advance),
    .item    (s1_item),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_item.last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_item.last_char) begin
      address_valid <= verdict;
    end
  end

endmodule
